[hdl/rdq_pkg.sv]
package rdq_pkg;

    // Store geometry.
    localparam int CAPACITY   = 32;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int POS_W      = 5;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] data_t;

    // Action codes.
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd1;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_INSERT_AT  = 3'd4;
    localparam logic [2:0] ACT_REMOVE_AT  = 3'd5;
    localparam logic [2:0] ACT_READ_AT    = 3'd6;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PUT,
        ST_DONE
    } state_t;

    // Request item.
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] value;
        logic [4:0]  position;
    } req_t;

    // Response item.
    typedef struct packed {
        logic        ok;
        logic [31:0] read_value;
        logic [5:0]  count;
        logic        is_full;
        logic        is_empty;
    } rsp_t;

    // Control from the top level to the engine.
    typedef struct packed {
        logic start;
        logic res_take;
    } eng_ctl_t;

    // Status from the engine to the top level.
    typedef struct packed {
        logic idle;
        logic res_valid;
    } eng_stat_t;

    // Ring index plus one.
    function automatic idx_t idx_inc(input idx_t a);
        return (a == IDX_W'(CAPACITY - 1)) ? '0 : a + IDX_W'(1);
    endfunction

    // Ring index minus one.
    function automatic idx_t idx_dec(input idx_t a);
        return (a == '0) ? IDX_W'(CAPACITY - 1) : a - IDX_W'(1);
    endfunction

    // Ring index sum; both operands are below the capacity.
    function automatic idx_t idx_add(input idx_t a, input idx_t b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= (IDX_W + 1)'(CAPACITY)) ? IDX_W'(s - (IDX_W + 1)'(CAPACITY))
                                             : IDX_W'(s);
    endfunction

endpackage

[hdl/ring_deque_with_positional_insert_core.sv]
// Double-ended queue of 32 elements of 32 bits held in a circular store.
// Request channel: req_valid, req_stall, req (action, value, position).
// Response channel: rsp_valid, rsp_stall, rsp (ok, read_value, count,
// is_full, is_empty). Every request gives exactly one response item.
// An item is taken when valid is high and stall is low at a clock edge.
// Push, pop and read go from acceptance straight to the done state, and
// the response item is then moved into the output register. Insert and
// remove at a position first move the shorter side of the contents one
// element per cycle through the store (insert then writes the new element
// in a final state) before the done state. Moves is at most half the count.
// req_stall is high from acceptance until the response leaves the engine,
// so one item is in work at a time. The response sits in an output
// register; a stalled receiver holds it there and the next response waits
// in the engine. Reset empties the queue (head and count cleared); the
// element store itself is not cleared, since only live elements are read.
module ring_deque_with_positional_insert_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rdq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rdq_pkg::rsp_t rsp
);

    rdq_pkg::eng_ctl_t  ctl;
    rdq_pkg::eng_stat_t stat;
    rdq_pkg::rsp_t      eng_rsp;
    logic               rsp_valid_reg, rsp_valid_next;
    rdq_pkg::rsp_t      rsp_reg;

    rdq_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .req   (req),
        .stat  (stat),
        .rsp   (eng_rsp)
    );

    // Handshake with the engine.
    assign req_stall    = !stat.idle;
    assign ctl.start    = req_valid && stat.idle;
    assign ctl.res_take = stat.res_valid && (!rsp_valid_reg || !rsp_stall);

    assign rsp_valid_next = ctl.res_take || (rsp_valid_reg && rsp_stall);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.res_take)
        begin
            rsp_reg <= eng_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The count reported never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.count <= 6'(rdq_pkg::CAPACITY))
        else $error("count above capacity");

    // Full and empty flags agree with the count.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.is_full == (rsp.count == 6'(rdq_pkg::CAPACITY)))
                      && (rsp.is_empty == (rsp.count == 6'd0)))
        else $error("flags disagree with count");

    // A refused request returns zero data.
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.ok) |-> rsp.read_value == 32'd0)
        else $error("refused request returned data");

    // After a request is taken the engine is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("second request taken while busy");

endmodule

[hdl/rdq_engine.sv]
module rdq_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  rdq_pkg::eng_ctl_t ctl,
    input  rdq_pkg::req_t     req,
    output rdq_pkg::eng_stat_t stat,
    output rdq_pkg::rsp_t     rsp
);

    rdq_pkg::state_t state_reg, state_next;
    rdq_pkg::idx_t   head_reg, head_next;
    rdq_pkg::cnt_t   cnt_reg, cnt_next;
    rdq_pkg::idx_t   src_reg, src_next;
    logic            dir_up_reg, dir_up_next;
    rdq_pkg::cnt_t   left_reg, left_next;
    logic            pend_reg, pend_next;
    rdq_pkg::idx_t   pend_dst_reg, pend_dst_next;
    rdq_pkg::idx_t   put_reg, put_next;
    rdq_pkg::data_t  put_val_reg, put_val_next;
    logic            ins_reg, ins_next;
    logic            ok_reg, ok_next;
    logic            rd_ok_reg, rd_ok_next;

    // Element store, one write port and one registered read port.
    rdq_pkg::data_t  mem [rdq_pkg::CAPACITY];
    rdq_pkg::data_t  rdata_reg;
    logic            wr_en;
    rdq_pkg::idx_t   wr_addr;
    rdq_pkg::data_t  wr_data;
    logic            rd_en;
    rdq_pkg::idx_t   rd_addr;

    // Sequencer: decodes the request, then, for insert and remove at a position, moves one element per cycle.
    always_comb
    begin
        logic [rdq_pkg::CMP_W-1:0] pos_c;
        logic [rdq_pkg::CMP_W-1:0] half_c;
        logic                      in_range;
        logic                      not_full;
        logic                      not_empty;
        logic                      back;
        rdq_pkg::idx_t             pos_idx;
        rdq_pkg::idx_t             at_pos;
        rdq_pkg::cnt_t             pos_n;

        state_next    = state_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        src_next      = src_reg;
        dir_up_next   = dir_up_reg;
        left_next     = left_reg;
        pend_next     = 1'b0;
        pend_dst_next = pend_dst_reg;
        put_next      = put_reg;
        put_val_next  = put_val_reg;
        ins_next      = ins_reg;
        ok_next       = ok_reg;
        rd_ok_next    = rd_ok_reg;
        wr_en         = 1'b0;
        wr_addr       = pend_dst_reg;
        wr_data       = rdata_reg;
        rd_en         = 1'b0;
        rd_addr       = src_reg;

        pos_c     = rdq_pkg::CMP_W'(req.position);
        half_c    = rdq_pkg::CMP_W'(cnt_reg >> 1);
        in_range  = pos_c < rdq_pkg::CMP_W'(cnt_reg);
        not_full  = cnt_reg != rdq_pkg::CNT_W'(rdq_pkg::CAPACITY);
        not_empty = cnt_reg != '0;
        back      = pos_c > half_c;
        pos_idx   = rdq_pkg::IDX_W'(req.position);
        pos_n     = rdq_pkg::CNT_W'(req.position);
        at_pos    = rdq_pkg::idx_add(head_reg, pos_idx);

        unique case (state_reg)
            rdq_pkg::ST_IDLE:
            begin
                if (ctl.start)
                begin
                    ok_next    = 1'b0;
                    rd_ok_next = 1'b0;
                    ins_next   = 1'b0;
                    left_next  = '0;
                    state_next = rdq_pkg::ST_DONE;
                    case (req.action)
                        rdq_pkg::ACT_PUSH_FRONT:
                        begin
                            if (not_full)
                            begin
                                head_next = rdq_pkg::idx_dec(head_reg);
                                wr_en     = 1'b1;
                                wr_addr   = rdq_pkg::idx_dec(head_reg);
                                wr_data   = rdq_pkg::DATA_WIDTH'(req.value);
                                cnt_next  = cnt_reg + rdq_pkg::CNT_W'(1);
                                ok_next   = 1'b1;
                            end
                        end
                        rdq_pkg::ACT_POP_FRONT:
                        begin
                            if (not_empty)
                            begin
                                head_next = rdq_pkg::idx_inc(head_reg);
                                cnt_next  = cnt_reg - rdq_pkg::CNT_W'(1);
                                ok_next   = 1'b1;
                            end
                        end
                        rdq_pkg::ACT_PUSH_BACK:
                        begin
                            if (not_full)
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = rdq_pkg::idx_add(head_reg,
                                                            rdq_pkg::IDX_W'(cnt_reg));
                                wr_data  = rdq_pkg::DATA_WIDTH'(req.value);
                                cnt_next = cnt_reg + rdq_pkg::CNT_W'(1);
                                ok_next  = 1'b1;
                            end
                        end
                        rdq_pkg::ACT_POP_BACK:
                        begin
                            if (not_empty)
                            begin
                                cnt_next = cnt_reg - rdq_pkg::CNT_W'(1);
                                ok_next  = 1'b1;
                            end
                        end
                        rdq_pkg::ACT_INSERT_AT:
                        begin
                            if (not_full && in_range)
                            begin
                                ok_next      = 1'b1;
                                ins_next     = 1'b1;
                                put_val_next = rdq_pkg::DATA_WIDTH'(req.value);
                                cnt_next     = cnt_reg + rdq_pkg::CNT_W'(1);
                                state_next   = rdq_pkg::ST_SHIFT;
                                if (back)
                                begin
                                    // Move the tail up by one, last element first.
                                    src_next    = rdq_pkg::idx_add(head_reg,
                                        rdq_pkg::IDX_W'(cnt_reg - rdq_pkg::CNT_W'(1)));
                                    dir_up_next = 1'b0;
                                    left_next   = cnt_reg - pos_n;
                                    put_next    = at_pos;
                                end
                                else
                                begin
                                    // Move the front down by one, first element first.
                                    src_next    = head_reg;
                                    dir_up_next = 1'b1;
                                    left_next   = pos_n;
                                    put_next    = rdq_pkg::idx_dec(at_pos);
                                    head_next   = rdq_pkg::idx_dec(head_reg);
                                end
                            end
                        end
                        rdq_pkg::ACT_REMOVE_AT:
                        begin
                            if (in_range)
                            begin
                                ok_next    = 1'b1;
                                cnt_next   = cnt_reg - rdq_pkg::CNT_W'(1);
                                state_next = rdq_pkg::ST_SHIFT;
                                if (back)
                                begin
                                    // Close the gap by pulling the tail down.
                                    src_next    = rdq_pkg::idx_inc(at_pos);
                                    dir_up_next = 1'b1;
                                    left_next   = cnt_reg - pos_n - rdq_pkg::CNT_W'(1);
                                end
                                else
                                begin
                                    // Close the gap by pushing the front up.
                                    src_next    = rdq_pkg::idx_dec(at_pos);
                                    dir_up_next = 1'b0;
                                    left_next   = pos_n;
                                    head_next   = rdq_pkg::idx_inc(head_reg);
                                end
                            end
                        end
                        rdq_pkg::ACT_READ_AT:
                        begin
                            if (in_range)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = at_pos;
                                rd_ok_next = 1'b1;
                                ok_next    = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rdq_pkg::ST_SHIFT:
            begin
                // Write back the element read in the previous cycle.
                if (pend_reg)
                begin
                    wr_en = 1'b1;
                end
                if (left_reg != '0)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = src_reg;
                    pend_next     = 1'b1;
                    pend_dst_next = dir_up_reg ? rdq_pkg::idx_dec(src_reg)
                                               : rdq_pkg::idx_inc(src_reg);
                    src_next      = dir_up_reg ? rdq_pkg::idx_inc(src_reg)
                                               : rdq_pkg::idx_dec(src_reg);
                    left_next     = left_reg - rdq_pkg::CNT_W'(1);
                end
                else
                begin
                    state_next = ins_reg ? rdq_pkg::ST_PUT : rdq_pkg::ST_DONE;
                end
            end
            rdq_pkg::ST_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = put_reg;
                wr_data    = put_val_reg;
                state_next = rdq_pkg::ST_DONE;
            end
            rdq_pkg::ST_DONE:
            begin
                if (ctl.res_take)
                begin
                    state_next = rdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rdq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdq_pkg::ST_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
            ins_reg   <= 1'b0;
            ok_reg    <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
            pend_reg  <= pend_next;
            ins_reg   <= ins_next;
            ok_reg    <= ok_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    // Address and data registers.
    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        dir_up_reg   <= dir_up_next;
        pend_dst_reg <= pend_dst_next;
        put_reg      <= put_next;
        put_val_reg  <= put_val_next;
    end

    // Element store.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Result fields; the read data stays put until the next read.
    assign rsp.ok         = ok_reg;
    assign rsp.read_value = rd_ok_reg ? 32'(rdata_reg) : 32'd0;
    assign rsp.count      = 6'(cnt_reg);
    assign rsp.is_full    = cnt_reg == rdq_pkg::CNT_W'(rdq_pkg::CAPACITY);
    assign rsp.is_empty   = cnt_reg == '0;

    assign stat.idle      = state_reg == rdq_pkg::ST_IDLE;
    assign stat.res_valid = state_reg == rdq_pkg::ST_DONE;

endmodule
